// File: design/suks_pkg.sv
// Package for the sorted unique key set: capacity, derived widths, operation codes
// and the control bundle that the top level broadcasts to every cell.
// No dependencies; every other design file imports it.
package suks_pkg;

  // Number of cells, which is the most keys that the set can hold.
  localparam int unsigned CAPACITY = 64;

  // Width of a cell index and of a count that can reach CAPACITY.
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Widths of the beat fields.
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 7;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  // Control broadcast to all cells in the cycle that a beat is accepted.
  typedef struct packed {
    logic                    clear;
    logic                    insert;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: design/suks_req_if.sv
// Request channel of the sorted unique key set: operation code and key.
// Depends on suks_pkg for the field widths.
interface suks_req_if;
  import suks_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [KEY_W-1:0]  key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

// File: design/suks_rsp_if.sv
// Response channel of the sorted unique key set: rank, flags and entry count.
// Depends on suks_pkg for the field widths.
interface suks_rsp_if;
  import suks_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic              was_present;
  logic              dropped_full;
  logic [POS_W-1:0]  entry_count;

  modport source (output valid, output position, output was_present,
                  output dropped_full, output entry_count, input ready);
  modport sink   (input valid, input position, input was_present,
                  input dropped_full, input entry_count, output ready);
endinterface

// File: design/sorted_unique_key_set.sv
// Top level of the sorted unique key set: the cell chain, rank encoder,
// entry counter and response register. Depends on suks_pkg, suks_req_if,
// suks_rsp_if and suks_cell.
//
// Usage: the block keeps up to CAPACITY distinct signed keys in ascending order
// in a row of cells. Each request beat carries an operation (clear, insert,
// look up) and a key; each request yields exactly one response beat with the
// key's rank, a present flag, a full-drop flag and the entry count afterwards.
// All cells compare against the key in the cycle the beat is accepted and an
// insert shifts the upper cells by one place in that same edge, so the
// response appears in the cycle after acceptance and a new request can be taken
// every cycle. The path that bounds the clock is the per-cell 32-bit compare
// followed by the OR of all match flags that decides whether cells shift.
// The response sits in an output register: while the receiver stalls, a
// pending response holds and no new request is taken, and a request is taken
// in the same cycle that the pending response is taken. Reset empties the set
// and the response register; no clearing pass is needed.
module sorted_unique_key_set
  import suks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  suks_req_if.sink    req_i,
  suks_rsp_if.source  rsp_o
);

  logic                    accept;
  logic                    hit;
  logic                    full;
  logic                    any_bound;
  logic [IDX_W-1:0]        enc_idx;
  logic [CNT_W-1:0]        rank;
  cell_ctrl_t              ctrl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_live;
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     bound;

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    rsp_valid_q, rsp_valid_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    present_q, present_d;
  logic                    dropped_q, dropped_d;

  // A request is taken whenever the response register is free or draining.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Global match and full flags.
  assign hit  = |cell_eq;
  assign full = (count_q == CNT_W'(CAPACITY));

  // Broadcast control to the chain.
  always_comb begin
    ctrl.key    = req_i.key;
    ctrl.clear  = accept && (req_i.func == FUNC_CLEAR);
    ctrl.insert = accept && (req_i.func == FUNC_INSERT) && !hit && !full;
  end

  // Row of cells; cell zero sees a virtual lower neighbor that is below every key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      suks_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .prev_key_i  (req_i.key),
        .prev_lt_i   (1'b1),
        .prev_live_i (1'b1),
        .key_o       (cell_key[i]),
        .live_o      (cell_live[i]),
        .lt_o        (cell_lt[i]),
        .eq_o        (cell_eq[i])
      );
      assign bound[i] = !cell_lt[i];
    end else begin : g_next
      suks_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .prev_key_i  (cell_key[i-1]),
        .prev_lt_i   (cell_lt[i-1]),
        .prev_live_i (cell_live[i-1]),
        .key_o       (cell_key[i]),
        .live_o      (cell_live[i]),
        .lt_o        (cell_lt[i]),
        .eq_o        (cell_eq[i])
      );
      assign bound[i] = cell_lt[i-1] && !cell_lt[i];
    end
  end

  // The below-key flags form a thermometer, so exactly one cell marks the rank
  // unless every cell holds a smaller key, in which case the rank is the count.
  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound[i]) begin
        enc_idx = enc_idx | IDX_W'(i);
      end
    end
  end

  assign any_bound = |bound;
  assign rank      = any_bound ? CNT_W'(enc_idx) : count_q;

  // Next count and response payload.
  always_comb begin
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    pos_d       = pos_q;
    present_d   = present_q;
    dropped_d   = dropped_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
      pos_d       = '0;
      present_d   = 1'b0;
      dropped_d   = 1'b0;
      case (req_i.func)
        FUNC_CLEAR: begin
          count_d = '0;
        end
        FUNC_INSERT: begin
          pos_d = POS_W'(rank);
          if (hit) begin
            present_d = 1'b1;
          end else if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_LOOKUP: begin
          present_d = hit;
          pos_d     = hit ? POS_W'(rank) : POS_W'(count_q);
        end
        default: begin
          pos_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Response payload needs no reset.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    present_q <= present_d;
    dropped_q <= dropped_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.position     = pos_q;
  assign rsp_o.was_present  = present_q;
  assign rsp_o.dropped_full = dropped_q;
  assign rsp_o.entry_count  = POS_W'(count_q);

`ifndef ASSERT_OFF
  // The count never passes the number of cells.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The live flags of the chain always agree with the count.
  a_live_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_live) == int'(count_q))
    else $error("live cells disagree with entry count");

  // A clear empties the set at the next edge.
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.func == FUNC_CLEAR) |=> count_q == '0)
    else $error("clear did not empty the set");

  // Stored keys never repeat, so at most one cell matches.
  a_one_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_eq))
    else $error("key stored in more than one cell");

  // A response cannot report both a present key and a full drop.
  a_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(present_q && dropped_q))
    else $error("present and dropped flags both set");
`endif

endmodule

// File: design/suks_cell.sv
// One storage cell of the sorted key chain: holds a key and its live flag,
// compares against the broadcast key and shifts from its lower neighbor on insert.
// Depends on suks_pkg.
module suks_cell
  import suks_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [KEY_W-1:0] prev_key_i,
  input  logic                    prev_lt_i,
  input  logic                    prev_live_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic                    live_o,
  output logic                    lt_o,
  output logic                    eq_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    live_q, live_d;

  // Only live entries take part in the search.
  assign lt_o = live_q && (key_q < ctrl_i.key);
  assign eq_o = live_q && (key_q == ctrl_i.key);

  // On insert, cells below the rank keep their key, the cell at the rank takes
  // the new key, and every cell above it takes its lower neighbor's key.
  always_comb begin
    key_d  = key_q;
    live_d = live_q;
    if (ctrl_i.clear) begin
      live_d = 1'b0;
    end else if (ctrl_i.insert && !lt_o) begin
      if (prev_lt_i) begin
        key_d  = ctrl_i.key;
        live_d = 1'b1;
      end else begin
        key_d  = prev_key_i;
        live_d = prev_live_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_d;
    end
  end

  // Key storage carries no reset; dead entries are never used.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o  = key_q;
  assign live_o = live_q;

endmodule

// File: bench/tb.sv
// Testbench for the sorted unique key set: random and directed request beats, with a
// self-checking scoreboard that predicts every response beat. Depends on suks_pkg,
// suks_req_if, suks_rsp_if and the sorted_unique_key_set top level.
`timescale 1ns / 100ps

module tb;
  import suks_pkg::*;

  // Operation code that the block must answer without changing anything.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  // Fields of one response beat.
  typedef struct {
    logic [POS_W-1:0] position;
    logic             was_present;
    logic             dropped_full;
    logic [POS_W-1:0] entry_count;
  } key_set_result_t;

  // Shadow copy of the ordered key store plus the queue of responses still owed.
  class key_set_scoreboard;
    logic signed [KEY_W-1:0] keys[CAPACITY];
    int unsigned             live;
    key_set_result_t         awaited[$];
    int unsigned             errors;

    function new();
      live   = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    function int unsigned count();
      return live;
    endfunction

    function logic signed [KEY_W-1:0] held_key(int unsigned idx);
      return keys[idx];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Apply one accepted request to the shadow store and queue its response.
    function void note_request(logic [FUNC_W-1:0] op, logic signed [KEY_W-1:0] k);
      key_set_result_t r;
      int unsigned     rank;
      bit              hit;
      r.position     = '0;
      r.was_present  = 1'b0;
      r.dropped_full = 1'b0;
      rank = 0;
      while (rank < live && keys[rank] < k) rank++;
      hit = (rank < live) && (keys[rank] == k);
      case (op)
        FUNC_CLEAR: begin
          live = 0;
        end
        FUNC_INSERT: begin
          r.position = POS_W'(rank);
          if (hit) begin
            r.was_present = 1'b1;
          end else if (live >= CAPACITY) begin
            r.dropped_full = 1'b1;
          end else begin
            for (int j = live; j > rank; j--) keys[j] = keys[j-1];
            keys[rank] = k;
            live++;
          end
        end
        FUNC_LOOKUP: begin
          r.was_present = hit;
          r.position    = hit ? POS_W'(rank) : POS_W'(live);
        end
        default: begin
        end
      endcase
      r.entry_count = POS_W'(live);
      awaited.push_back(r);
    endfunction

    // Compare one accepted response beat with the oldest expectation.
    task check_response(key_set_result_t got);
      key_set_result_t want;
      if (awaited.size() == 0) begin
        report("response beat with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      if (got.position !== want.position)
        report($sformatf("position %0d, expected %0d", got.position, want.position));
      if (got.was_present !== want.was_present)
        report($sformatf("was_present %b, expected %b", got.was_present, want.was_present));
      if (got.dropped_full !== want.dropped_full)
        report($sformatf("dropped_full %b, expected %b", got.dropped_full,
                         want.dropped_full));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                         want.entry_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  key_set_scoreboard sb = new();

  suks_req_if req_bus ();
  suks_rsp_if rsp_bus ();

  sorted_unique_key_set dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #4 clk_i = ~clk_i;

  // Run limit in case the block stops answering.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Response side: check accepted beats and stall the block in random bursts.
  always @(posedge clk_i) begin
    key_set_result_t got;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.position     = rsp_bus.position;
        got.was_present  = rsp_bus.was_present;
        got.dropped_full = rsp_bus.dropped_full;
        got.entry_count  = rsp_bus.entry_count;
        sb.check_response(got);
      end
      if (calm) begin
        rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Drive one request beat, with an optional idle burst in front, and wait for it
  // to be taken. Called and returning at a rising edge.
  task automatic send(logic [FUNC_W-1:0] op, logic signed [KEY_W-1:0] k);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.func  <= op;
    req_bus.key   <= k;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(op, k);
  endtask

  // Keys are biased toward coarse degree values and stored neighbors so that
  // duplicates and near misses are common.
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    int unsigned             n;
    int                      deg;
    n = sb.count();
    k = $urandom;
    case ($urandom_range(0, 9))
      2, 3, 4: begin
        deg = int'($urandom_range(0, 40)) - 20;
        k   = deg <<< 16;
      end
      5, 6: begin
        if (n > 0) k = sb.held_key($urandom_range(0, n - 1));
      end
      7: begin
        case ($urandom_range(0, 5))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = KEY_MIN + 1;
          3: k = KEY_MAX - 1;
          4: k = '0;
          default: k = '1;
        endcase
      end
      8, 9: begin
        if (n > 0) begin
          k = sb.held_key($urandom_range(0, n - 1));
          k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end
      end
      default: begin
      end
    endcase
    return k;
  endfunction

  initial begin
    int unsigned full_stay;
    int unsigned full_hold;
    int unsigned dice;
    rst_ni        <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.func  <= FUNC_CLEAR;
    req_bus.key   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty store, extremes, duplicates, absent keys, unused code, clears.
    send(FUNC_LOOKUP, 32'sd5);
    send(FUNC_INSERT, 32'sd0);
    send(FUNC_INSERT, KEY_MIN);
    send(FUNC_INSERT, KEY_MAX);
    send(FUNC_INSERT, -32'sd1);
    send(FUNC_INSERT, 32'sd1);
    send(FUNC_INSERT, 32'sd0);
    send(FUNC_INSERT, KEY_MAX);
    send(FUNC_LOOKUP, KEY_MIN);
    send(FUNC_LOOKUP, KEY_MAX);
    send(FUNC_LOOKUP, 32'sd2);
    send(FUNC_LOOKUP, KEY_MIN + 1);
    send(FUNC_UNUSED, 32'sd1);
    send(FUNC_UNUSED, KEY_MAX);
    send(FUNC_INSERT, 32'sh0001_8000);
    send(FUNC_CLEAR, KEY_MAX);
    send(FUNC_LOOKUP, 32'sd0);
    send(FUNC_INSERT, 32'sd0);
    send(FUNC_LOOKUP, 32'sd0);
    send(FUNC_CLEAR, KEY_MIN);
    send(FUNC_CLEAR, 32'sd0);

    // Random part: fill the store, keep it full for a while, then clear it.
    full_stay = 0;
    full_hold = $urandom_range(10, 60);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      if (sb.count() == CAPACITY) full_stay++;
      if (full_stay > full_hold) begin
        send(FUNC_CLEAR, pick_key());
        full_stay = 0;
        full_hold = $urandom_range(10, 60);
      end else begin
        dice = $urandom_range(0, 99);
        if (dice < 3)
          send(FUNC_UNUSED, pick_key());
        else if (dice < 4)
          send(FUNC_CLEAR, pick_key());
        else if (dice < 70)
          send(FUNC_INSERT, pick_key());
        else
          send(FUNC_LOOKUP, pick_key());
      end
    end

    // Drain: wait for every owed response, then give the verdict.
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
design/suks_pkg.sv
design/suks_req_if.sv
design/suks_rsp_if.sv
design/suks_cell.sv
design/sorted_unique_key_set.sv
bench/tb.sv
